[rtl/mflrd_pkg.sv]
// mflrd_pkg: opcodes, field widths and coordinate types for the line/rect drawer
// no dependencies

package mflrd_pkg;

  localparam int OP_W      = 3;
  localparam int FIELD_W   = 11;
  localparam int CRD_W     = 12;
  localparam int ERR_W     = 14;
  localparam int IN_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 3'd1;
  localparam logic [OP_W-1:0] OP_LINE  = 3'd2;
  localparam logic [OP_W-1:0] OP_RECT  = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ  = 3'd5;

  localparam logic [7:0] MASK_MSB = 8'h80;
  localparam logic [7:0] MASK_LSB = 8'h01;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [ERR_W-1:0] err_t;

endpackage

[rtl/mono_framebuffer_line_rect_drawer.sv]
// mono_framebuffer_line_rect_drawer: 1-bpp packed framebuffer with pixel/line/rect commands
// the walker steps through every pixel, clipped ones too, then drains the pipe and replies
// throughput: one pixel a cycle on the read-modify-write path, next command once the reply is registered
// clear command and reset: a clearing pass over all ROW_BYTES*PANEL_HEIGHT bytes, one byte a cycle
// reset (rst_n low, synchronous) clears control state and then runs the clearing pass
// depends on mflrd_pkg

module mono_framebuffer_line_rect_drawer #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // operation, x_start, y_start, x_end, y_end from bit 0 up
  input  logic [mflrd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // read_data
  output logic [7:0]                          out_tdata,
  // is_read_reply
  output logic [0:0]                          out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mflrd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
  localparam mflrd_pkg::crd_t PW_S = mflrd_pkg::CRD_W'(PANEL_WIDTH);
  localparam mflrd_pkg::crd_t PH_S = mflrd_pkg::CRD_W'(PANEL_HEIGHT);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_POINT, ST_LINE, ST_HEDGE, ST_VEDGE, ST_FILL, ST_DRAIN, ST_DONE
  } state_t;

  // configuration
  logic msb_first_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, msb_first_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msb_first_r <= 1'b0;
    end else if (cfg_wr) begin
      msb_first_r <= cfg_pwdata[0];
    end
  end

  // input fields
  logic [mflrd_pkg::OP_W-1:0] in_op;
  mflrd_pkg::crd_t in_xs, in_ys, in_xe, in_ye;
  mflrd_pkg::crd_t in_dx, in_dy, in_ddx, in_ddy;
  logic in_acc;

  assign in_op  = in_tdata[2:0];
  assign in_xs  = mflrd_pkg::CRD_W'($signed(in_tdata[13:3]));
  assign in_ys  = mflrd_pkg::CRD_W'($signed(in_tdata[24:14]));
  assign in_xe  = mflrd_pkg::CRD_W'($signed(in_tdata[35:25]));
  assign in_ye  = mflrd_pkg::CRD_W'($signed(in_tdata[46:36]));
  assign in_dx  = in_xe - in_xs;
  assign in_dy  = in_ye - in_ys;
  assign in_ddx = in_dx[mflrd_pkg::CRD_W-1] ? -in_dx : in_dx;
  assign in_ddy = in_dy[mflrd_pkg::CRD_W-1] ? in_dy : -in_dy;

  // walker registers
  state_t state_r;
  mflrd_pkg::crd_t cx_r, cy_r, x0_r, y0_r, x1_r, y1_r, ddx_r, ddy_r;
  mflrd_pkg::err_t err_r;
  logic stx_neg_r, sty_neg_r, half_r, rd_op_r, clr_cmd_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [7:0] res_data_r;
  logic out_tvalid_r, out_rd_r;
  logic [7:0] out_data_r;

  // current pixel
  mflrd_pkg::crd_t px, py;
  logic walking, on_panel, pix_go;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0] pix_mask;

  always_comb begin
    case (state_r)
      ST_HEDGE: begin
        px = cx_r;
        py = half_r ? y1_r : y0_r;
      end
      ST_VEDGE: begin
        px = half_r ? x1_r : x0_r;
        py = cy_r;
      end
      default: begin
        px = cx_r;
        py = cy_r;
      end
    endcase
  end

  assign walking  = (state_r == ST_POINT) || (state_r == ST_LINE) || (state_r == ST_HEDGE) ||
                    (state_r == ST_VEDGE) || (state_r == ST_FILL);
  assign on_panel = !px[mflrd_pkg::CRD_W-1] && (px < PW_S) &&
                    !py[mflrd_pkg::CRD_W-1] && (py < PH_S);
  assign pix_go   = walking && on_panel;
  assign pix_addr = ADDR_W'(py[9:0]) * ROW_BYTES_A + ADDR_W'(px[9:3]);
  assign pix_mask = msb_first_r ? (mflrd_pkg::MASK_MSB >> px[2:0])
                                : (mflrd_pkg::MASK_LSB << px[2:0]);

  // bresenham step
  logic signed [mflrd_pkg::ERR_W:0] e2;
  logic step_x, step_y, line_end;
  mflrd_pkg::err_t err_step;

  assign e2       = {err_r, 1'b0};
  assign step_x   = e2 >= (mflrd_pkg::ERR_W+1)'(ddy_r);
  assign step_y   = e2 <= (mflrd_pkg::ERR_W+1)'(ddx_r);
  assign err_step = err_r + (step_x ? mflrd_pkg::ERR_W'(ddy_r) : '0)
                          + (step_y ? mflrd_pkg::ERR_W'(ddx_r) : '0);
  assign line_end = (cx_r == x1_r) && (cy_r == y1_r);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // read-modify-write pipe
  logic [7:0] mem [DEPTH];
  logic [7:0] mem_rdata_r;
  logic s1_valid_r, s1_rd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [7:0] s1_mask_r;
  logic fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [7:0] fwd_data_r;
  logic [7:0] merged;
  logic pix_we, mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0] mem_wdata;

  assign merged    = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : mem_rdata_r;
  assign pix_we    = s1_valid_r && !s1_rd_r;
  assign mem_we    = pix_we || (state_r == ST_CLEAR);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : s1_addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? 8'd0 : (merged | s1_mask_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pix_go) begin
      mem_rdata_r <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= pix_addr;
    s1_mask_r  <= pix_mask;
    s1_rd_r    <= rd_op_r;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= mem_wdata;
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= pix_go;
      fwd_valid_r <= pix_we;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_cmd_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      rd_op_r      <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (s1_valid_r && s1_rd_r) begin
        res_data_r <= merged;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= clr_cmd_r ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cx_r       <= in_xs;
            cy_r       <= in_ys;
            x0_r       <= in_xs;
            y0_r       <= in_ys;
            x1_r       <= in_xe;
            y1_r       <= in_ye;
            ddx_r      <= in_ddx;
            ddy_r      <= in_ddy;
            err_r      <= mflrd_pkg::ERR_W'(in_ddx) + mflrd_pkg::ERR_W'(in_ddy);
            stx_neg_r  <= !(in_xs < in_xe);
            sty_neg_r  <= !(in_ys < in_ye);
            half_r     <= 1'b0;
            rd_op_r    <= (in_op == mflrd_pkg::OP_READ);
            res_data_r <= 8'd0;
            clr_cmd_r  <= (in_op == mflrd_pkg::OP_CLEAR);
            case (in_op)
              mflrd_pkg::OP_CLEAR: state_r <= ST_CLEAR;
              mflrd_pkg::OP_PIXEL, mflrd_pkg::OP_READ: state_r <= ST_POINT;
              mflrd_pkg::OP_LINE: state_r <= ST_LINE;
              mflrd_pkg::OP_RECT: begin
                if (in_xs <= in_xe) begin
                  state_r <= ST_HEDGE;
                end else if (in_ys <= in_ye) begin
                  state_r <= ST_VEDGE;
                end else begin
                  state_r <= ST_DONE;
                end
              end
              mflrd_pkg::OP_FILL: begin
                state_r <= ((in_xs <= in_xe) && (in_ys <= in_ye)) ? ST_FILL : ST_DONE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_POINT: state_r <= ST_DRAIN;
        ST_LINE: begin
          if (line_end) begin
            state_r <= ST_DRAIN;
          end else begin
            err_r <= err_step;
            if (step_x) begin
              cx_r <= stx_neg_r ? cx_r - 1'b1 : cx_r + 1'b1;
            end
            if (step_y) begin
              cy_r <= sty_neg_r ? cy_r - 1'b1 : cy_r + 1'b1;
            end
          end
        end
        ST_HEDGE: begin
          half_r <= !half_r;
          if (half_r) begin
            if (cx_r == x1_r) begin
              cy_r    <= y0_r;
              state_r <= (y0_r <= y1_r) ? ST_VEDGE : ST_DRAIN;
            end else begin
              cx_r <= cx_r + 1'b1;
            end
          end
        end
        ST_VEDGE: begin
          half_r <= !half_r;
          if (half_r) begin
            if (cy_r == y1_r) begin
              state_r <= ST_DRAIN;
            end else begin
              cy_r <= cy_r + 1'b1;
            end
          end
        end
        ST_FILL: begin
          if (cx_r == x1_r) begin
            cx_r <= x0_r;
            if (cy_r == y1_r) begin
              state_r <= ST_DRAIN;
            end else begin
              cy_r <= cy_r + 1'b1;
            end
          end else begin
            cx_r <= cx_r + 1'b1;
          end
        end
        ST_DRAIN: state_r <= ST_DONE;
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= rd_op_r ? res_data_r : 8'd0;
            out_rd_r     <= rd_op_r;
            rd_op_r      <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rd_r;

  // checks
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !s1_valid_r && !pix_go)
    else $error("pixel pipe busy while taking a command");

  a_reply_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 8'd0))
    else $error("nonzero data on a non-read reply");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second command taken while one is in flight");

endmodule
